/* rtl/nrtp_pkg.sv */
// Package for the nearest ray/triangle pick core.
// It holds the shared types, the product sequence table and the saturation helper.
// It depends on nothing else.
package nrtp_pkg;

	localparam int GRID_MAX_DEF  = 256;
	localparam int FRAC_BITS_DEF = 16;
	localparam int EPS_LSB_DEF   = 1;
	localparam int NUM_UOPS      = 24;
	localparam int ACC_W         = 66;

	typedef enum logic [4:0] {
		OP_D0, OP_D1, OP_D2, OP_E10, OP_E11, OP_E12, OP_E20, OP_E21, OP_E22,
		OP_S0, OP_S1, OP_S2, OP_H0, OP_H1, OP_H2, OP_Q0, OP_Q1, OP_Q2
	} oper_t;

	typedef enum logic [3:0] {
		DST_NONE, DST_H0, DST_H1, DST_H2, DST_DEN, DST_NU,
		DST_Q0, DST_Q1, DST_Q2, DST_NV, DST_NT
	} dst_t;

	typedef enum logic [1:0] {DIV_U, DIV_V, DIV_T} div_sel_t;

	typedef enum logic [2:0] {
		CFG_OX, CFG_OY, CFG_OZ, CFG_DX, CFG_DY, CFG_DZ, CFG_SIDE
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_ACC, ST_DIV_GO, ST_DIV_WAIT, ST_DECIDE
	} state_t;

	typedef struct packed {
		oper_t a;
		oper_t b;
		logic  neg;
		logic  first;
		logic  last;
		dst_t  dst;
	} uop_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		logic     acc_en;
		uop_t     uop;
		logic     div_go;
		div_sel_t div_sel;
		logic     commit;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic fin;
		logic out_free;
	} sts_t;

	// Products of h = dir x e2, den, s.h, q = s x e1, dir.q and e2.q.
	function automatic uop_t ucode(input logic [4:0] i);
		uop_t u;
		case (i)
			5'd0:    u = '{OP_D1,  OP_E22, 1'b0, 1'b1, 1'b0, DST_NONE};
			5'd1:    u = '{OP_D2,  OP_E21, 1'b1, 1'b0, 1'b1, DST_H0};
			5'd2:    u = '{OP_D2,  OP_E20, 1'b0, 1'b1, 1'b0, DST_NONE};
			5'd3:    u = '{OP_D0,  OP_E22, 1'b1, 1'b0, 1'b1, DST_H1};
			5'd4:    u = '{OP_D0,  OP_E21, 1'b0, 1'b1, 1'b0, DST_NONE};
			5'd5:    u = '{OP_D1,  OP_E20, 1'b1, 1'b0, 1'b1, DST_H2};
			5'd6:    u = '{OP_E10, OP_H0,  1'b0, 1'b1, 1'b0, DST_NONE};
			5'd7:    u = '{OP_E11, OP_H1,  1'b0, 1'b0, 1'b0, DST_NONE};
			5'd8:    u = '{OP_E12, OP_H2,  1'b0, 1'b0, 1'b1, DST_DEN};
			5'd9:    u = '{OP_S0,  OP_H0,  1'b0, 1'b1, 1'b0, DST_NONE};
			5'd10:   u = '{OP_S1,  OP_H1,  1'b0, 1'b0, 1'b0, DST_NONE};
			5'd11:   u = '{OP_S2,  OP_H2,  1'b0, 1'b0, 1'b1, DST_NU};
			5'd12:   u = '{OP_S1,  OP_E12, 1'b0, 1'b1, 1'b0, DST_NONE};
			5'd13:   u = '{OP_S2,  OP_E11, 1'b1, 1'b0, 1'b1, DST_Q0};
			5'd14:   u = '{OP_S2,  OP_E10, 1'b0, 1'b1, 1'b0, DST_NONE};
			5'd15:   u = '{OP_S0,  OP_E12, 1'b1, 1'b0, 1'b1, DST_Q1};
			5'd16:   u = '{OP_S0,  OP_E11, 1'b0, 1'b1, 1'b0, DST_NONE};
			5'd17:   u = '{OP_S1,  OP_E10, 1'b1, 1'b0, 1'b1, DST_Q2};
			5'd18:   u = '{OP_D0,  OP_Q0,  1'b0, 1'b1, 1'b0, DST_NONE};
			5'd19:   u = '{OP_D1,  OP_Q1,  1'b0, 1'b0, 1'b0, DST_NONE};
			5'd20:   u = '{OP_D2,  OP_Q2,  1'b0, 1'b0, 1'b1, DST_NV};
			5'd21:   u = '{OP_E20, OP_Q0,  1'b0, 1'b1, 1'b0, DST_NONE};
			5'd22:   u = '{OP_E21, OP_Q1,  1'b0, 1'b0, 1'b0, DST_NONE};
			5'd23:   u = '{OP_E22, OP_Q2,  1'b0, 1'b0, 1'b1, DST_NT};
			default: u = '{OP_D0,  OP_D0,  1'b0, 1'b1, 1'b0, DST_NONE};
		endcase
		return u;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
		logic signed [31:0] r;
		if (x > $signed(ACC_W'(32'h7FFFFFFF)))
			r = 32'sh7FFFFFFF;
		else if (x < -$signed(ACC_W'(33'h080000000)))
			r = 32'sh80000000;
		else
			r = x[31:0];
		return r;
	endfunction

endpackage

/* rtl/nrtp_ctrl.sv */
// Controller of the nearest ray/triangle pick core.
// It sequences the products, the three divisions and the final decision.
// It depends on nrtp_pkg.
module nrtp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  nrtp_pkg::sts_t sts,
	output nrtp_pkg::cmd_t cmd
);

	nrtp_pkg::state_t     state_q, state_n;
	logic [4:0]           step_q, step_n;
	nrtp_pkg::div_sel_t   div_q, div_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nrtp_pkg::ST_IDLE;
			step_q  <= '0;
			div_q   <= nrtp_pkg::DIV_U;
		end else begin
			state_q <= state_n;
			step_q  <= step_n;
			div_q   <= div_n;
		end
	end

	always_comb begin
		state_n     = state_q;
		step_n      = step_q;
		div_n       = div_q;
		s_tready    = 1'b0;
		cmd         = '0;
		cmd.uop     = nrtp_pkg::ucode(step_q);
		cmd.div_sel = div_q;
		case (state_q)
			nrtp_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					step_n   = '0;
					state_n  = nrtp_pkg::ST_MUL;
				end
			end
			nrtp_pkg::ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_n    = nrtp_pkg::ST_ACC;
			end
			nrtp_pkg::ST_ACC: begin
				cmd.acc_en = 1'b1;
				if (step_q == 5'(nrtp_pkg::NUM_UOPS - 1)) begin
					div_n   = nrtp_pkg::DIV_U;
					state_n = nrtp_pkg::ST_DIV_GO;
				end else begin
					step_n  = step_q + 5'd1;
					state_n = nrtp_pkg::ST_MUL;
				end
			end
			nrtp_pkg::ST_DIV_GO: begin
				cmd.div_go = 1'b1;
				state_n    = nrtp_pkg::ST_DIV_WAIT;
			end
			nrtp_pkg::ST_DIV_WAIT: begin
				if (sts.div_done) begin
					case (div_q)
						nrtp_pkg::DIV_U: begin
							div_n   = nrtp_pkg::DIV_V;
							state_n = nrtp_pkg::ST_DIV_GO;
						end
						nrtp_pkg::DIV_V: begin
							div_n   = nrtp_pkg::DIV_T;
							state_n = nrtp_pkg::ST_DIV_GO;
						end
						default: state_n = nrtp_pkg::ST_DECIDE;
					endcase
				end
			end
			nrtp_pkg::ST_DECIDE: begin
				if (!sts.fin || sts.out_free) begin
					cmd.commit = 1'b1;
					state_n    = nrtp_pkg::ST_IDLE;
				end
			end
			default: state_n = nrtp_pkg::ST_IDLE;
		endcase
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == nrtp_pkg::ST_MUL)
		else $error("accepted transaction did not start the product sequence");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == nrtp_pkg::ST_DECIDE && sts.fin && !sts.out_free
		|=> state_q == nrtp_pkg::ST_DECIDE)
		else $error("result overwritten while the previous one was pending");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == nrtp_pkg::ST_MUL |-> step_q < 5'(nrtp_pkg::NUM_UOPS))
		else $error("product step out of range");

endmodule

/* rtl/nrtp_dpath.sv */
// Datapath of the nearest ray/triangle pick core: registers, shared multiplier,
// bit-serial divider, running best hit, grid walk and output register.
// It depends on nrtp_pkg.
module nrtp_dpath #(
	parameter int GRID_MAX  = nrtp_pkg::GRID_MAX_DEF,
	parameter int FRAC_BITS = nrtp_pkg::FRAC_BITS_DEF,
	parameter int EPS_LSB   = nrtp_pkg::EPS_LSB_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [31:0]    cfg_data,
	input  logic [287:0]   s_tdata,
	input  logic           s_tlast,
	input  nrtp_pkg::cmd_t cmd,
	output nrtp_pkg::sts_t sts,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [55:0]    m_tdata
);

	localparam int DW = 32 + FRAC_BITS;
	localparam int CW = $clog2(DW + 1);
	localparam int AW = nrtp_pkg::ACC_W;

	logic signed [31:0] ox_q, oy_q, oz_q, dx_q, dy_q, dz_q;
	logic [8:0]         side_q;
	logic signed [31:0] e1_q [3];
	logic signed [31:0] e2_q [3];
	logic signed [31:0] s_q [3];
	logic signed [31:0] h_q [3];
	logic signed [31:0] qv_q [3];
	logic signed [31:0] den_q, nu_q, nv_q, nt_q, u_q, v_q, t_q;
	logic [15:0]        idx0_q, idx1_q, idx2_q;
	logic               fin_q;
	logic signed [63:0] prod_s1;
	logic signed [AW-1:0] acc_q;

	logic signed [31:0] best_q;
	logic [15:0]        best_idx_q;
	logic               any_q;
	logic [7:0]         row_q, col_q;
	logic               half_q;
	logic               out_valid_q;
	logic [48:0]        out_q;

	logic               busy_q, done_q, neg_q;
	logic [CW-1:0]      cnt_q;
	logic [31:0]        rem_q, dvs_q;
	logic [DW-1:0]      dvd_q, quo_q;

	function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [AW-1:0] d;
		d = AW'(a) - AW'(b);
		return nrtp_pkg::sat32(d);
	endfunction

	function automatic logic signed [31:0] opnd(input nrtp_pkg::oper_t o,
			input logic signed [31:0] d0, input logic signed [31:0] d1,
			input logic signed [31:0] d2);
		logic signed [31:0] r;
		case (o)
			nrtp_pkg::OP_D0:  r = d0;
			nrtp_pkg::OP_D1:  r = d1;
			nrtp_pkg::OP_D2:  r = d2;
			nrtp_pkg::OP_E10: r = e1_q[0];
			nrtp_pkg::OP_E11: r = e1_q[1];
			nrtp_pkg::OP_E12: r = e1_q[2];
			nrtp_pkg::OP_E20: r = e2_q[0];
			nrtp_pkg::OP_E21: r = e2_q[1];
			nrtp_pkg::OP_E22: r = e2_q[2];
			nrtp_pkg::OP_S0:  r = s_q[0];
			nrtp_pkg::OP_S1:  r = s_q[1];
			nrtp_pkg::OP_S2:  r = s_q[2];
			nrtp_pkg::OP_H0:  r = h_q[0];
			nrtp_pkg::OP_H1:  r = h_q[1];
			nrtp_pkg::OP_H2:  r = h_q[2];
			nrtp_pkg::OP_Q0:  r = qv_q[0];
			nrtp_pkg::OP_Q1:  r = qv_q[1];
			nrtp_pkg::OP_Q2:  r = qv_q[2];
			default:          r = '0;
		endcase
		return r;
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q   <= '0;
			oy_q   <= '0;
			oz_q   <= '0;
			dx_q   <= '0;
			dy_q   <= '0;
			dz_q   <= 32'sh00010000;
			side_q <= 9'd2;
		end else if (cfg_we) begin
			case (nrtp_pkg::cfg_idx_t'(cfg_index))
				nrtp_pkg::CFG_OX:   ox_q   <= cfg_data;
				nrtp_pkg::CFG_OY:   oy_q   <= cfg_data;
				nrtp_pkg::CFG_OZ:   oz_q   <= cfg_data;
				nrtp_pkg::CFG_DX:   dx_q   <= cfg_data;
				nrtp_pkg::CFG_DY:   dy_q   <= cfg_data;
				nrtp_pkg::CFG_DZ:   dz_q   <= cfg_data;
				nrtp_pkg::CFG_SIDE: side_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	logic [8:0]  side;
	logic [17:0] rs0, rs1, tl, bl;
	logic signed [31:0] va [3];
	logic signed [31:0] vb [3];
	logic signed [31:0] vc [3];

	always_comb begin
		if (side_q < 9'd2)
			side = 9'd2;
		else if (side_q > 9'(GRID_MAX))
			side = 9'(GRID_MAX);
		else
			side = side_q;
		rs0 = 18'(row_q) * 18'(side);
		rs1 = rs0 + 18'(side);
		tl  = rs0 + 18'(col_q);
		bl  = rs1 + 18'(col_q);
		for (int k = 0; k < 3; k++) begin
			va[k] = s_tdata[32*k +: 32];
			vb[k] = s_tdata[32*(k+3) +: 32];
			vc[k] = s_tdata[32*(k+6) +: 32];
		end
	end

	// Capture of one triangle.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int k = 0; k < 3; k++) begin
				e1_q[k] <= sub_sat(vb[k], va[k]);
				e2_q[k] <= sub_sat(vc[k], va[k]);
			end
			s_q[0] <= sub_sat(ox_q, va[0]);
			s_q[1] <= sub_sat(oy_q, va[1]);
			s_q[2] <= sub_sat(oz_q, va[2]);
			fin_q  <= s_tlast;
			if (half_q) begin
				idx0_q <= bl[15:0];
				idx1_q <= 16'(bl + 18'd1);
			end else begin
				idx0_q <= tl[15:0];
				idx1_q <= bl[15:0];
			end
			idx2_q <= 16'(tl + 18'd1);
		end
	end

	// Shared multiplier and accumulator.
	logic signed [63:0]   fp;
	logic signed [AW-1:0] acc_n;
	logic signed [31:0]   acc_sat;

	always_comb begin
		fp = prod_s1 >>> FRAC_BITS;
		if (cmd.uop.neg)
			acc_n = (cmd.uop.first ? AW'(0) : acc_q) - AW'(fp);
		else
			acc_n = (cmd.uop.first ? AW'(0) : acc_q) + AW'(fp);
		acc_sat = nrtp_pkg::sat32(acc_n);
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			prod_s1 <= opnd(cmd.uop.a, dx_q, dy_q, dz_q) * opnd(cmd.uop.b, dx_q, dy_q, dz_q);
		if (cmd.acc_en) begin
			acc_q <= acc_n;
			if (cmd.uop.last) begin
				case (cmd.uop.dst)
					nrtp_pkg::DST_H0:  h_q[0]  <= acc_sat;
					nrtp_pkg::DST_H1:  h_q[1]  <= acc_sat;
					nrtp_pkg::DST_H2:  h_q[2]  <= acc_sat;
					nrtp_pkg::DST_DEN: den_q   <= acc_sat;
					nrtp_pkg::DST_NU:  nu_q    <= acc_sat;
					nrtp_pkg::DST_Q0:  qv_q[0] <= acc_sat;
					nrtp_pkg::DST_Q1:  qv_q[1] <= acc_sat;
					nrtp_pkg::DST_Q2:  qv_q[2] <= acc_sat;
					nrtp_pkg::DST_NV:  nv_q    <= acc_sat;
					nrtp_pkg::DST_NT:  nt_q    <= acc_sat;
					default: ;
				endcase
			end
		end
	end

	// Restoring divider, one quotient bit per cycle.
	logic signed [31:0] num;
	logic [31:0]        num_mag, den_mag;
	logic [32:0]        r2;
	logic               qbit;
	logic signed [31:0] quot;

	always_comb begin
		case (cmd.div_sel)
			nrtp_pkg::DIV_U: num = nu_q;
			nrtp_pkg::DIV_V: num = nv_q;
			default:         num = nt_q;
		endcase
		num_mag = num[31] ? 32'(-num) : num;
		den_mag = den_q[31] ? 32'(-den_q) : den_q;
		r2      = {rem_q, dvd_q[DW-1]};
		qbit    = r2 >= {1'b0, dvs_q};
		if (!neg_q)
			quot = (quo_q > DW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : quo_q[31:0];
		else
			quot = (quo_q > DW'(33'h080000000)) ? 32'sh80000000 : 32'(-quo_q[31:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !cmd.div_go && busy_q && (cnt_q == CW'(DW - 1));
			if (cmd.div_go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DW - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_go) begin
			rem_q <= '0;
			dvs_q <= den_mag;
			dvd_q <= {num_mag, FRAC_BITS'(0)};
			quo_q <= '0;
			neg_q <= num[31] ^ den_q[31];
		end else if (busy_q) begin
			rem_q <= qbit ? 32'(r2 - {1'b0, dvs_q}) : r2[31:0];
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			quo_q <= {quo_q[DW-2:0], qbit};
		end
		if (done_q) begin
			case (cmd.div_sel)
				nrtp_pkg::DIV_U: u_q <= quot;
				nrtp_pkg::DIV_V: v_q <= quot;
				default:         t_q <= quot;
			endcase
		end
	end

	// Hit test and choice of vertex.
	localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;
	localparam logic signed [31:0] EPS = 32'(EPS_LSB);

	logic signed [33:0] u_x, v_x, w0;
	logic               hit, new_any;
	logic [15:0]        pick, new_idx;
	logic signed [31:0] new_dist;
	logic [8:0]         c1;

	always_comb begin
		u_x = 34'(u_q);
		v_x = 34'(v_q);
		w0  = ONE - u_x - v_x;
		hit = (den_q <= -EPS || den_q >= EPS) && u_x >= 0 && u_x <= ONE && v_x >= 0
			&& (u_x + v_x) <= ONE && t_q > EPS && (!any_q || t_q < best_q);
		if (w0 >= u_x && w0 >= v_x)
			pick = idx0_q;
		else if (u_x >= v_x)
			pick = idx1_q;
		else
			pick = idx2_q;
		new_any  = any_q | hit;
		new_idx  = hit ? pick : best_idx_q;
		new_dist = hit ? t_q : best_q;
		c1       = 9'(col_q) + 9'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q      <= 32'sh7FFFFFFF;
			best_idx_q  <= '0;
			any_q       <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			half_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (cmd.commit && fin_q) || (out_valid_q && !m_tready);
			if (cmd.commit) begin
				if (fin_q) begin
					best_q      <= 32'sh7FFFFFFF;
					best_idx_q  <= '0;
					any_q       <= 1'b0;
					row_q       <= '0;
					col_q       <= '0;
					half_q      <= 1'b0;
				end else begin
					best_q     <= new_dist;
					best_idx_q <= new_idx;
					any_q      <= new_any;
					if (half_q) begin
						half_q <= 1'b0;
						if (c1 >= side - 9'd1) begin
							col_q <= '0;
							row_q <= row_q + 8'd1;
						end else begin
							col_q <= c1[7:0];
						end
					end else begin
						half_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && fin_q)
			out_q <= new_any ? {new_dist, new_idx, 1'b1} : '0;
	end

	assign sts.div_done = done_q;
	assign sts.fin      = fin_q;
	assign sts.out_free = !out_valid_q || m_tready;
	assign m_tvalid     = out_valid_q;
	assign m_tdata      = {7'b0, out_q};

	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> $past(m_tready))
		else $error("result dropped without a transaction");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider finished without running");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_go |-> !busy_q)
		else $error("divider started while busy");

endmodule

/* rtl/nearest_ray_triangle_pick_core.sv */
// Nearest ray/triangle pick: one triangle per transaction. Each takes 24 products on one shared
// multiplier and three bit-serial divisions, and no new triangle is accepted until the last
// one is done. The result of a final triangle is held until taken.
// Reset is asynchronous, active low; it restores the ray registers and clears the run.
// Depends on nrtp_pkg, nrtp_ctrl and nrtp_dpath.
module nearest_ray_triangle_pick_core #(
	parameter int GRID_MAX  = nrtp_pkg::GRID_MAX_DEF,
	parameter int FRAC_BITS = nrtp_pkg::FRAC_BITS_DEF,
	parameter int EPS_LSB   = nrtp_pkg::EPS_LSB_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, 32 bits each from the lowest bit.
	input  logic [287:0] s_tdata,
	// final_triangle.
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// hit_found, picked_particle (16), hit_distance (32), then zero fill.
	output logic [55:0]  m_tdata
);

	nrtp_pkg::cmd_t cmd;
	nrtp_pkg::sts_t sts;

	nrtp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	nrtp_dpath #(
		.GRID_MAX  (GRID_MAX),
		.FRAC_BITS (FRAC_BITS),
		.EPS_LSB   (EPS_LSB)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
